FILE: design/iupu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iupu_pkg: shared types and constants of the pixel unpacker
// Pixel format codes, register indexes, queue depth and the format decode.
// ----------------------------------------------------------------------------
package iupu_pkg;

  typedef enum logic [3:0] {
    FMT_CT32  = 4'd0,
    FMT_CT24  = 4'd1,
    FMT_CT16  = 4'd2,
    FMT_CT16S = 4'd3,
    FMT_T8    = 4'd4,
    FMT_T4    = 4'd5,
    FMT_T8H   = 4'd6,
    FMT_T4HL  = 4'd7,
    FMT_T4HH  = 4'd8,
    FMT_Z32   = 4'd9,
    FMT_Z24   = 4'd10,
    FMT_Z16   = 4'd11,
    FMT_Z16S  = 4'd12
  } fmt_t;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X      = 2'd0,
    REG_START_Y      = 2'd1,
    REG_RECT_WIDTH   = 2'd2,
    REG_PIXEL_FORMAT = 2'd3
  } cfg_reg_t;

  // result queue depth and its pointer width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = 2;

  // pushes into the result queue from one accepted word
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // bytes gathered per pixel; zero for byte and nibble formats
  function automatic logic [2:0] bytes_per_pixel(input logic [3:0] fmt);
    logic [2:0] n;
    case (fmt) inside
      FMT_CT32, FMT_Z32:                    n = 3'd4;
      FMT_CT24, FMT_Z24:                    n = 3'd3;
      FMT_CT16, FMT_CT16S, FMT_Z16, FMT_Z16S: n = 3'd2;
      default:                              n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: design/iupu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iupu_in_if: upload byte channel
// Valid/ready channel carrying one upload byte and its packet end flag.
// ----------------------------------------------------------------------------
interface iupu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, data_byte, packet_end, input ready);
  modport sink   (input valid, data_byte, packet_end, output ready);
endinterface

FILE: design/iupu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iupu_out_if: pixel write channel
// Valid/ready channel carrying one pixel write with its coordinates.
// ----------------------------------------------------------------------------
interface iupu_out_if #(parameter int COORD_BITS = 11);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [31:0]           pixel_value;
  logic                  run_last;

  modport source (output valid, pixel_x, pixel_y, pixel_value, run_last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_value, run_last, output ready);
endinterface

FILE: design/iupu_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iupu_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface iupu_cfg_if #(parameter int COORD_BITS = 11);
  logic                                  valid;
  logic                                  ready;
  logic [iupu_pkg::CFG_IDX_BITS-1:0]     index;
  logic [COORD_BITS:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/image_upload_pixel_unpacker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_upload_pixel_unpacker_core: upload byte stream to pixel writes
// Gathers little-endian bytes into pixels and walks a raster cursor over
// the destination rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch  - register writes (0 start_x, 1 start_y, 2 rect_width,
//             3 pixel_format). Always ready. Writing start_x / start_y
//             also loads the cursor; write them only while idle.
//   in_ch   - one upload word (byte plus packet_end) per handshake.
//   out_ch  - one pixel write per handshake: x, y, value, run_last.
// A pixel completed by an accepted word is pushed into the queue at the accept
//   edge and offered once older entries have gone. Throughput: one word per cycle,
//   while in_ch.ready is high, for the 32/24/16/8-bit formats; the 4-bit
//   formats yield two pixels per word and the single output port throttles them.
// The cursor and gather update in the accept cycle; results wait in a
//   4-entry queue. in_ch.ready is high while the queue holds two entries or
//   fewer, so a stalled receiver back-pressures the input once three or more
//   entries wait. out_ch.valid comes straight from the queue count.
// Reset (rst_n low, synchronous) clears the queue, cursor and gather and
//   sets start 0/0, width 1, format ct32.
// ----------------------------------------------------------------------------
module image_upload_pixel_unpacker_core #(
  parameter int COORD_BITS = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  iupu_cfg_if.sink         cfg_ch,
  iupu_in_if.sink          in_ch,
  iupu_out_if.source       out_ch
);

  localparam int EW = 2 * COORD_BITS + 33;

  iupu_pkg::push_t push;
  logic [EW-1:0]   ent0, ent1, rd;
  logic            rd_valid;
  logic [iupu_pkg::FIFO_PTR_BITS:0] fifo_cnt;
  logic            in_fire, out_fire, cfg_fire;

  // config is taken every cycle
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // room for the worst case of two pixels from one word
  assign in_ch.ready = (fifo_cnt <= (iupu_pkg::FIFO_PTR_BITS + 1)'(iupu_pkg::FIFO_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;

  iupu_unpack #(.COORD_BITS(COORD_BITS)) u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_fire),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .in_fire    (in_fire),
    .data_byte  (in_ch.data_byte),
    .packet_end (in_ch.packet_end),
    .push       (push),
    .ent0       (ent0),
    .ent1       (ent1)
  );

  iupu_out_fifo #(.EW(EW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr0      (ent0),
    .wr1      (ent1),
    .pop      (out_fire),
    .rd       (rd),
    .rd_valid (rd_valid),
    .count    (fifo_cnt)
  );

  // entry layout: {x, y, value, last}
  assign out_ch.valid       = rd_valid;
  assign out_fire           = out_ch.valid && out_ch.ready;
  assign out_ch.pixel_x     = rd[EW-1 -: COORD_BITS];
  assign out_ch.pixel_y     = rd[EW-1-COORD_BITS -: COORD_BITS];
  assign out_ch.pixel_value = rd[32:1];
  assign out_ch.run_last    = rd[0];

  // a word is only taken when the queue can absorb both nibble pixels
  a_room_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (fifo_cnt <= (iupu_pkg::FIFO_PTR_BITS + 1)'(iupu_pkg::FIFO_DEPTH - 2)))
    else $error("word accepted without room for two pixels");

  // a pixel that is not last of its word always has its partner pushed with it
  a_pair_complete : assert property (@(posedge clk) disable iff (!rst_n)
    (push.first && !ent0[0]) |-> push.second)
    else $error("first nibble pixel pushed without its partner");

  // the queue count holds still when there is neither a push nor a pop
  a_count_track : assert property (@(posedge clk) disable iff (!rst_n)
    (!push.first && !out_fire) |=> (fifo_cnt == $past(fifo_cnt)))
    else $error("queue count moved without a push or pop");

endmodule

FILE: design/iupu_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iupu_unpack: register file, raster cursor and byte gather
// Turns one accepted byte into up to two queue entries in the same cycle.
// ----------------------------------------------------------------------------
module iupu_unpack #(
  parameter  int COORD_BITS = 11,
  localparam int EW         = 2 * COORD_BITS + 33
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [iupu_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS:0]               cfg_data,
  input  logic                              in_fire,
  input  logic [7:0]                        data_byte,
  input  logic                              packet_end,
  output iupu_pkg::push_t                   push,
  output logic [EW-1:0]                     ent0,
  output logic [EW-1:0]                     ent1
);

  // start_y only loads the row cursor, so it has no register of its own
  logic [COORD_BITS-1:0] start_x_r;
  logic [COORD_BITS:0]   width_r;
  logic [3:0]            fmt_r;
  logic [COORD_BITS-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [1:0]            gcnt_r, gcnt_nxt;
  logic [23:0]           gbytes_r, gbytes_nxt;

  logic [2:0]            need;
  logic [2:0]            cnt_inc;
  logic [31:0]           gathered, pix_mask, val0, val1;
  logic                  last0;
  logic [COORD_BITS-1:0] x1, y1, x2, y2;

  // one raster step: wrap to start_x once x+1 reaches start_x + width
  function automatic logic [2*COORD_BITS-1:0] step(input logic [COORD_BITS-1:0] x,
                                                   input logic [COORD_BITS-1:0] y,
                                                   input logic [COORD_BITS-1:0] sx,
                                                   input logic [COORD_BITS:0]   w);
    logic [COORD_BITS+1:0] nx;
    logic [COORD_BITS+1:0] ex;
    nx = {2'b00, x} + {{(COORD_BITS+1){1'b0}}, 1'b1};
    ex = {2'b00, sx} + {1'b0, w};
    if (nx >= ex) begin
      return {sx, y + {{(COORD_BITS-1){1'b0}}, 1'b1}};
    end
    return {nx[COORD_BITS-1:0], y};
  endfunction

  assign need     = iupu_pkg::bytes_per_pixel(fmt_r);
  assign cnt_inc  = {1'b0, gcnt_r} + 3'd1;
  assign gathered = {8'd0, gbytes_r} | ({24'd0, data_byte} << {gcnt_r, 3'b000});

  always_comb begin
    case (need)
      3'd2:    pix_mask = 32'h0000_ffff;
      3'd3:    pix_mask = 32'h00ff_ffff;
      default: pix_mask = 32'hffff_ffff;
    endcase
  end

  assign {x1, y1} = step(cx_r, cy_r, start_x_r, width_r);
  assign {x2, y2} = step(x1, y1, start_x_r, width_r);

  always_comb begin
    push       = '0;
    val0       = '0;
    val1       = '0;
    last0      = 1'b1;
    gcnt_nxt   = gcnt_r;
    gbytes_nxt = gbytes_r;
    if (in_fire) begin
      if (need != 3'd0) begin
        if (cnt_inc >= need) begin
          push.first = 1'b1;
          val0       = gathered & pix_mask;
          gcnt_nxt   = '0;
          gbytes_nxt = '0;
        end else begin
          gcnt_nxt   = cnt_inc[1:0];
          gbytes_nxt = gathered[23:0];
        end
      end else if (fmt_r inside {iupu_pkg::FMT_T8, iupu_pkg::FMT_T8H}) begin
        push.first = 1'b1;
        val0       = {24'd0, data_byte};
      end else if (fmt_r inside {iupu_pkg::FMT_T4, iupu_pkg::FMT_T4HL,
                                 iupu_pkg::FMT_T4HH}) begin
        push.first  = 1'b1;
        push.second = 1'b1;
        val0        = {28'd0, data_byte[3:0]};
        val1        = {28'd0, data_byte[7:4]};
        last0       = 1'b0;
      end
      if (packet_end) begin
        gcnt_nxt   = '0;
        gbytes_nxt = '0;
      end
    end
  end

  always_comb begin
    if (push.second) begin
      cx_nxt = x2;
      cy_nxt = y2;
    end else if (push.first) begin
      cx_nxt = x1;
      cy_nxt = y1;
    end else begin
      cx_nxt = cx_r;
      cy_nxt = cy_r;
    end
  end

  assign ent0 = {cx_r, cy_r, val0, last0};
  assign ent1 = {x1, y1, val1, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      width_r   <= {{COORD_BITS{1'b0}}, 1'b1};
      fmt_r     <= iupu_pkg::FMT_CT32;
      cx_r      <= '0;
      cy_r      <= '0;
      gcnt_r    <= '0;
      gbytes_r  <= '0;
    end else begin
      gcnt_r   <= gcnt_nxt;
      gbytes_r <= gbytes_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      if (cfg_we) begin
        case (iupu_pkg::cfg_reg_t'(cfg_index))
          iupu_pkg::REG_START_X: begin
            start_x_r <= cfg_data[COORD_BITS-1:0];
            cx_r      <= cfg_data[COORD_BITS-1:0];
          end
          iupu_pkg::REG_START_Y: begin
            cy_r      <= cfg_data[COORD_BITS-1:0];
          end
          iupu_pkg::REG_RECT_WIDTH:   width_r <= cfg_data;
          iupu_pkg::REG_PIXEL_FORMAT: fmt_r   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: design/iupu_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iupu_out_fifo: pixel write queue
// Takes up to two entries a cycle, hands out one a cycle from a register.
// ----------------------------------------------------------------------------
module iupu_out_fifo #(
  parameter int EW = 55
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iupu_pkg::push_t      push,
  input  logic [EW-1:0]        wr0,
  input  logic [EW-1:0]        wr1,
  input  logic                 pop,
  output logic [EW-1:0]        rd,
  output logic                 rd_valid,
  output logic [iupu_pkg::FIFO_PTR_BITS:0] count
);

  localparam int PB = iupu_pkg::FIFO_PTR_BITS;

  logic [EW-1:0] mem_r [iupu_pkg::FIFO_DEPTH];
  logic [PB-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PB:0]   cnt_r, cnt_nxt, n_push;
  logic [PB-1:0] wp_plus1;

  assign n_push   = {{PB{1'b0}}, push.first} + {{PB{1'b0}}, push.second};
  assign wp_plus1 = wp_r + {{(PB-1){1'b0}}, 1'b1};
  assign wp_nxt   = wp_r + n_push[PB-1:0];
  assign rp_nxt   = rp_r + {{(PB-1){1'b0}}, pop};
  assign cnt_nxt  = cnt_r + n_push - {{PB{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wp_r] <= wr0;
    end
    if (push.second) begin
      mem_r[wp_plus1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign rd       = mem_r[rp_r];
  assign rd_valid = (cnt_r != '0);
  assign count    = cnt_r;

endmodule
